@@ hdl/ill_pkg.sv @@
package ill_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the request and result channels
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_DELETE     = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

@@ hdl/ill_if.sv @@
interface ill_cmd_if import ill_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface ill_res_if import ill_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        list_length;
  status_t                 status;

  modport source (output valid, read_value, list_length, status, input ready);
  modport sink (input valid, read_value, list_length, status, output ready);
endinterface

@@ hdl/ill_ram.sv @@
module ill_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/indexed_list_insert_delete_core.sv @@
// Ordered list of up to CAPACITY signed entries held in one single-port-write,
// registered-read RAM. Each request (read, push front/back, insert, pop
// front/back, delete, clear) gives exactly one result: the value read (zero
// unless a read succeeds), the length after the request and a status (ok,
// bad position, empty, full). After reset the list holds one zero entry; the
// first cycle after reset writes that entry and no request is taken then.
// Path of a request from acceptance to the result entering the output
// register: clear, pop back, popping the only entry and every failed request
// go there directly; a read first waits for the registered RAM read; an
// append (push back, or an insert or push front at the end of the list)
// writes the value; an insert or push front that moves entries first shifts
// them towards the end, last entry first, then writes the value; a delete or
// pop front that moves entries shifts the later entries towards the front.
// The RAM write port moves one entry per cycle while the gap is opened or
// closed. A finished result waits in the output register, so the next
// request may be accepted meanwhile; a result that finds the output register
// still occupied and not being taken holds until it is.
module indexed_list_insert_delete_core import ill_pkg::*; (
  input  logic clk,
  input  logic rst,
  ill_cmd_if.sink   cmd,
  ill_res_if.source res
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SHIFT, S_TAIL, S_PUTVAL, S_RDWAIT, S_PUT
  } state_t;

  state_t  state;
  count_t  count;
  logic    up;        // shift direction: towards the end when set
  logic    pipe;      // rdata carries an entry to move
  addr_t   rd_addr;
  addr_t   end_addr;
  addr_t   src;       // address that rdata came from
  addr_t   tgt;       // slot for the inserted value
  data_t   ins_val;

  logic signed [VAL_W-1:0] res_value;
  logic [LEN_W-1:0]        res_len;
  status_t                 res_status;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic [LEN_W-1:0]        out_len;
  status_t                 out_status;

  // RAM port signals
  logic  mem_we;
  addr_t mem_waddr;
  data_t mem_wdata;
  addr_t mem_raddr;
  data_t mem_rdata;

  // Decode of the request at the input
  logic             accept;
  cmd_t             cmd_e;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] ins_p;
  logic [CMP_W-1:0] del_p;
  status_t          dec_status;
  count_t           dec_count;
  state_t           dec_next;
  logic             dec_up;
  addr_t            dec_start;
  addr_t            dec_end;
  addr_t            dec_tgt;
  addr_t            shift_waddr;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  assign res.valid       = out_valid;
  assign res.read_value  = out_value;
  assign res.list_length = out_len;
  assign res.status      = out_status;

  assign cmd_e = cmd_t'(cmd.command);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);
  assign pos_c = CMP_W'(cmd.position);
  assign cnt_c = CMP_W'(count);

  always_comb begin
    dec_status = ST_OK;
    dec_count  = count;
    dec_next   = S_PUT;
    dec_up     = 1'b1;
    dec_start  = '0;
    dec_end    = '0;
    dec_tgt    = '0;
    ins_p      = '0;
    del_p      = '0;
    unique case (cmd_e)
      CMD_READ: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_next = S_RDWAIT;
        end
      end
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (cmd_e == CMD_PUSH_FRONT) begin
          ins_p = '0;
        end else if (cmd_e == CMD_PUSH_BACK) begin
          ins_p = cnt_c;
        end else begin
          ins_p = pos_c;
        end
        if (full) begin
          dec_status = ST_FULL;
        end else if (ins_p > cnt_c) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_count = count + 1'b1;
          dec_tgt   = ADDR_W'(ins_p);
          if (ins_p == cnt_c) begin
            // append: no entry moves
            dec_next = S_PUTVAL;
          end else begin
            dec_next  = S_SHIFT;
            dec_up    = 1'b1;
            dec_start = ADDR_W'(count - 1'b1);
            dec_end   = ADDR_W'(ins_p);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE: begin
        if (cmd_e == CMD_POP_FRONT) begin
          del_p = '0;
        end else if (cmd_e == CMD_POP_BACK) begin
          del_p = cnt_c - 1'b1;
        end else begin
          del_p = pos_c;
        end
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (del_p >= cnt_c) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_count = count - 1'b1;
          if (del_p != cnt_c - 1'b1) begin
            dec_next  = S_SHIFT;
            dec_up    = 1'b0;
            dec_start = ADDR_W'(del_p + 1'b1);
            dec_end   = ADDR_W'(count - 1'b1);
          end
        end
      end
      CMD_CLEAR: begin
        dec_count = '0;
      end
    endcase
  end

  // Move each entry one place towards the end or the front
  assign shift_waddr = up ? addr_t'(src + 1'b1) : addr_t'(src - 1'b1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = shift_waddr;
    mem_wdata = mem_rdata;
    mem_raddr = (state == S_IDLE) ? ADDR_W'(cmd.position) : rd_addr;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '0;
      end
      S_SHIFT: begin
        mem_we = pipe;
      end
      S_TAIL: begin
        mem_we = 1'b1;
      end
      S_PUTVAL: begin
        mem_we    = 1'b1;
        mem_waddr = tgt;
        mem_wdata = ins_val;
      end
      S_IDLE, S_RDWAIT, S_PUT: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ill_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CNT_W'(1);
      out_valid <= 1'b0;
      pipe      <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded below
      if (res.ready && state != S_PUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            count      <= dec_count;
            res_status <= dec_status;
            res_len    <= LEN_W'(dec_count);
            res_value  <= '0;
            up         <= dec_up;
            rd_addr    <= dec_start;
            end_addr   <= dec_end;
            tgt        <= dec_tgt;
            ins_val    <= DATA_WIDTH'($unsigned(cmd.value));
            pipe       <= 1'b0;
            state      <= dec_next;
          end
        end
        S_SHIFT: begin
          pipe <= 1'b1;
          src  <= rd_addr;
          if (rd_addr == end_addr) begin
            state <= S_TAIL;
          end else begin
            rd_addr <= up ? addr_t'(rd_addr - 1'b1) : addr_t'(rd_addr + 1'b1);
          end
        end
        S_TAIL: begin
          state <= up ? S_PUTVAL : S_PUT;
        end
        S_PUTVAL: begin
          state <= S_PUT;
        end
        S_RDWAIT: begin
          // sign-extend from the stored width
          res_value <= VAL_W'($signed(mem_rdata));
          state     <= S_PUT;
        end
        S_PUT: begin
          // hold until the output register is free
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_len    <= res_len;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
